>>> rtl/csct_pkg.sv
// shared types and constants for the cube-sphere cell tessellator
// no dependencies; imported by the top level
package csct_pkg;

    localparam int FACE_W      = 3;
    localparam int CELL_W      = 8;
    localparam int DIV_W       = 9;
    localparam int SLOT_W      = 3;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_SLOTS   = 6;
    localparam int NUM_AXES    = 3;
    localparam int NUM_TRIS    = 2;

    // grid size ceiling and fraction bits of the Q2 words
    localparam int MAX_DIVISIONS = 256;
    localparam int FRAC_BITS     = 14;

    // corner coordinates in units of 1/divisions, and their squares
    localparam int COORD_W = 11;
    localparam int CSQ_W   = 20;

    localparam logic [FACE_W-1:0] LAST_FACE = 3'd5;
    localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd5;
    localparam logic [SLOT_W-1:0] TRI1_SLOT = 3'd3;
    localparam logic [DIV_W-1:0]  DIV_RESET = 9'd1;

    typedef logic [1:0] corner_idx_t;

    // axis ordering per face pair
    typedef enum logic [1:0] {
        PAIR_XY = 2'd0,
        PAIR_YZ = 2'd1,
        PAIR_ZX = 2'd2
    } face_pair_t;

    // corner order of the six vertices for each face sign
    localparam corner_idx_t WIND_POS [NUM_SLOTS] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};
    localparam corner_idx_t WIND_NEG [NUM_SLOTS] = '{2'd0, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1};

endpackage

>>> rtl/csct_scale.sv
// pipelined unit scaler: round(|v| * 2^FRAC / sqrt(sq)) with sign, one result bit per stage
// depends on nothing but its parameters; used by the top level for corners and normals
module csct_scale #(
    parameter int FRAC  = 14,
    parameter int SQ_W  = 20,
    parameter int VSQ_W = 20
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic                   neg,
    input  logic [VSQ_W-1:0]       vsq,
    input  logic [SQ_W-1:0]        sq,
    output logic signed [FRAC+1:0] res
);

    localparam int STAGES = FRAC + 1;
    localparam int MW     = VSQ_W + 2 * FRAC;
    localparam int DW     = SQ_W + 2 * FRAC + 3;
    localparam int WW     = ((MW > DW) ? MW : DW) + 3;
    localparam int RW     = WW + 2;
    localparam logic [FRAC:0] BIT_ONE = 1;

    logic [WW-1:0] rem_reg [STAGES];
    logic [WW-1:0] p_reg   [STAGES];
    logic [WW-1:0] sq_reg  [STAGES];
    logic [FRAC:0] r_reg   [STAGES];
    logic          neg_reg [STAGES];
    logic          zero_reg[STAGES];

    logic signed [FRAC+1:0] res_reg;
    logic signed [FRAC+1:0] res_next;
    logic [RW-1:0]          rem4;
    logic [RW-1:0]          lim;
    logic                   round_up;
    logic [FRAC+1:0]        mag;

    // remainder holds M - r^2*sq, p holds r*sq
    for (genvar gs = 0; gs < STAGES; gs++) begin : g_it
        localparam int BIT = FRAC - gs;
        logic [WW-1:0] rem_in;
        logic [WW-1:0] p_in;
        logic [WW-1:0] sq_in;
        logic [WW-1:0] delta;
        logic [FRAC:0] r_in;
        logic          neg_in;
        logic          zero_in;

        if (gs == 0) begin : g_first
            assign rem_in  = WW'(vsq) << (2 * FRAC);
            assign p_in    = '0;
            assign sq_in   = WW'(sq);
            assign r_in    = '0;
            assign neg_in  = neg;
            assign zero_in = (sq == '0);
        end
        else begin : g_next
            assign rem_in  = rem_reg[gs-1];
            assign p_in    = p_reg[gs-1];
            assign sq_in   = sq_reg[gs-1];
            assign r_in    = r_reg[gs-1];
            assign neg_in  = neg_reg[gs-1];
            assign zero_in = zero_reg[gs-1];
        end

        assign delta = (p_in << (BIT + 1)) + (sq_in << (2 * BIT));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (delta <= rem_in)
                begin
                    rem_reg[gs] <= rem_in - delta;
                    p_reg[gs]   <= p_in + (sq_in << BIT);
                    r_reg[gs]   <= r_in | (BIT_ONE << BIT);
                end
                else
                begin
                    rem_reg[gs] <= rem_in;
                    p_reg[gs]   <= p_in;
                    r_reg[gs]   <= r_in;
                end
                sq_reg[gs]   <= sq_in;
                neg_reg[gs]  <= neg_in;
                zero_reg[gs] <= zero_in;
            end
        end
    end

    // round half away: bump when 4*rem >= 4*p + sq
    always_comb
    begin
        rem4     = {rem_reg[STAGES-1], 2'b00};
        lim      = {p_reg[STAGES-1], 2'b00} + RW'(sq_reg[STAGES-1]);
        round_up = (rem4 >= lim);
        mag      = {1'b0, r_reg[STAGES-1]} + {{(FRAC+1){1'b0}}, round_up};
        if (zero_reg[STAGES-1])
        begin
            res_next = '0;
        end
        else if (neg_reg[STAGES-1])
        begin
            res_next = -$signed(mag);
        end
        else
        begin
            res_next = $signed(mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/cube_sphere_cell_tessellator_unit.sv
// top level of the cube-sphere cell tessellator: corner build, projection, flat normals
// depends on csct_pkg and csct_scale
//
// one input word names a cell (face, row, column) of a cube whose faces are cut into
// grid_divisions squares a side; the block returns six output words, the vertices of the
// cell's two triangles projected onto the unit sphere, each with its triangle's unit flat
// normal, all signed Q2.FRAC_BITS. a cell with a face above five or a row or column not
// below the divisions is taken and gives no words. the output port delivers one word a
// cycle while out_stall is low. while a finished cell waits at the port the whole pipe,
// input included, stands still until the cell's sixth word is taken. the projection and
// normalising units each settle one result bit per stage, and every stage holds its own
// cell, so one cell per stage can be in flight. grid_divisions is written through
// cfg_we/cfg_data; the user must do so only while the block is idle, which the block does
// not itself enforce. zero acts as one and values above MAX_DIVISIONS act as MAX_DIVISIONS.
module cube_sphere_cell_tessellator_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [csct_pkg::DIV_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [csct_pkg::FACE_W-1:0]           face_index,
    input  logic [csct_pkg::CELL_W-1:0]           cell_row,
    input  logic [csct_pkg::CELL_W-1:0]           cell_col,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [csct_pkg::FRAC_BITS+1:0] pos_x,
    output logic signed [csct_pkg::FRAC_BITS+1:0] pos_y,
    output logic signed [csct_pkg::FRAC_BITS+1:0] pos_z,
    output logic signed [csct_pkg::FRAC_BITS+1:0] norm_x,
    output logic signed [csct_pkg::FRAC_BITS+1:0] norm_y,
    output logic signed [csct_pkg::FRAC_BITS+1:0] norm_z,
    output logic [csct_pkg::SLOT_W-1:0]           vertex_slot,
    output logic                                  last_vertex
);

    import csct_pkg::*;

    localparam int PW     = FRAC_BITS + 2;      // position / normal word
    localparam int DF_W   = FRAC_BITS + 3;      // edge vector component
    localparam int PR_W   = 2 * DF_W;           // cross product term
    localparam int C_W    = 2 * FRAC_BITS + 5;  // cross product component
    localparam int CM_W   = C_W - 1;
    localparam int NVSQ_W = 2 * CM_W;
    localparam int NSQ_W  = NVSQ_W + 2;
    localparam int LAT    = FRAC_BITS + 2;      // latency of one scaler

    // ---------------------------------------------------------------- config
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] div_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= DIV_RESET;
        end
        else if (cfg_we)
        begin
            div_reg <= cfg_data;
        end
    end

    // zero acts as one, large values clip to the maximum
    always_comb
    begin
        if (div_reg == '0)
        begin
            div_eff = DIV_RESET;
        end
        else if (32'(div_reg) > MAX_DIVISIONS)
        begin
            div_eff = DIV_W'(MAX_DIVISIONS);
        end
        else
        begin
            div_eff = div_reg;
        end
    end

    // ---------------------------------------------------------------- flow control
    logic                 en;
    logic                 out_take;
    logic                 in_ok;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic                 vn_reg [LAT];

    // the whole pipe moves together; it stops only while a finished cell waits at the port
    assign out_valid = vn_reg[LAT-1];
    assign out_take  = out_valid && !out_stall;
    assign en        = !out_valid || (out_take && (slot_reg == LAST_SLOT));
    assign in_stall  = !en;

    assign in_ok = (face_index <= LAST_FACE)
                && ({1'b0, cell_row} < div_eff)
                && ({1'b0, cell_col} < div_eff);

    always_comb
    begin
        slot_next = slot_reg;
        if (out_take)
        begin
            if (slot_reg == LAST_SLOT)
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    // ---------------------------------------------------------------- stage 1: input word
    logic              v1_reg;
    logic [FACE_W-1:0] face1_reg;
    logic [CELL_W-1:0] row1_reg;
    logic [CELL_W-1:0] col1_reg;
    logic [DIV_W-1:0]  div1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid && in_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face1_reg <= face_index;
            row1_reg  <= cell_row;
            col1_reg  <= cell_col;
            div1_reg  <= div_eff;
        end
    end

    // ---------------------------------------------------------------- stage 2: corners and squares
    logic signed [COORD_W-1:0] u0;
    logic signed [COORD_W-1:0] v0;
    logic signed [COORD_W-1:0] wv;
    logic signed [COORD_W-1:0] crd  [NUM_CORNERS][NUM_AXES];
    logic [COORD_W-1:0]        cful [NUM_CORNERS][NUM_AXES];
    logic [COORD_W-2:0]        cmag [NUM_CORNERS][NUM_AXES];
    logic [CSQ_W-1:0]          csqc [NUM_CORNERS][NUM_AXES];
    logic [CSQ_W+1:0]          csum [NUM_CORNERS];

    logic                      v2_reg;
    logic [FACE_W-1:0]         face2_reg;
    logic                      cneg2_reg [NUM_CORNERS][NUM_AXES];
    logic [CSQ_W-1:0]          cvsq2_reg [NUM_CORNERS][NUM_AXES];
    logic [CSQ_W-1:0]          csq2_reg  [NUM_CORNERS];

    always_comb
    begin
        u0 = $signed({2'b00, div1_reg}) - $signed({2'b00, col1_reg, 1'b0});
        v0 = $signed({2'b00, div1_reg}) - $signed({2'b00, row1_reg, 1'b0});
        wv = face1_reg[0] ? -$signed({2'b00, div1_reg}) : $signed({2'b00, div1_reg});
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            crd[k][0] = ((k == 1) || (k == 2)) ? u0 - COORD_W'(2) : u0;
            crd[k][1] = (k >= 2) ? v0 - COORD_W'(2) : v0;
            crd[k][2] = wv;
            for (int q = 0; q < NUM_AXES; q++)
            begin
                cful[k][q] = crd[k][q][COORD_W-1] ? COORD_W'(-crd[k][q]) : COORD_W'(crd[k][q]);
                cmag[k][q] = cful[k][q][COORD_W-2:0];
                csqc[k][q] = cmag[k][q] * cmag[k][q];
            end
            csum[k] = (CSQ_W + 2)'(csqc[k][0]) + (CSQ_W + 2)'(csqc[k][1])
                    + (CSQ_W + 2)'(csqc[k][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face2_reg <= face1_reg;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                csq2_reg[k] <= csum[k][CSQ_W-1:0];
                for (int q = 0; q < NUM_AXES; q++)
                begin
                    cneg2_reg[k][q] <= crd[k][q][COORD_W-1];
                    cvsq2_reg[k][q] <= csqc[k][q];
                end
            end
        end
    end

    // ---------------------------------------------------------------- corner projection
    // cres[k] holds (u, v, w) of corner k on the sphere, before axis mapping
    logic signed [PW-1:0] cres [NUM_CORNERS][NUM_AXES];

    for (genvar gk = 0; gk < NUM_CORNERS; gk++) begin : g_corner
        for (genvar gq = 0; gq < NUM_AXES; gq++) begin : g_axis
            csct_scale #(
                .FRAC  (FRAC_BITS),
                .SQ_W  (CSQ_W),
                .VSQ_W (CSQ_W)
            ) u_scale (
                .clk (clk),
                .en  (en),
                .neg (cneg2_reg[gk][gq]),
                .vsq (cvsq2_reg[gk][gq]),
                .sq  (csq2_reg[gk]),
                .res (cres[gk][gq])
            );
        end
    end

    logic              vc_reg    [LAT];
    logic [FACE_W-1:0] facec_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vc_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vc_reg[0] <= v2_reg;
            for (int i = 1; i < LAT; i++)
            begin
                vc_reg[i] <= vc_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            facec_reg[0] <= face2_reg;
            for (int i = 1; i < LAT; i++)
            begin
                facec_reg[i] <= facec_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage 3: axis map and cross product
    logic [FACE_W-1:0]     facec;
    logic signed [PW-1:0]  cxyz [NUM_CORNERS][NUM_AXES];
    logic signed [PW-1:0]  tv   [NUM_TRIS][NUM_AXES][NUM_AXES];
    logic signed [DF_W-1:0] ea  [NUM_TRIS][NUM_AXES];
    logic signed [DF_W-1:0] eb  [NUM_TRIS][NUM_AXES];
    logic signed [PR_W-1:0] crs [NUM_TRIS][NUM_AXES];
    corner_idx_t           tci;

    logic                  v3_reg;
    logic [FACE_W-1:0]     face3_reg;
    logic signed [PW-1:0]  cor3_reg [NUM_CORNERS][NUM_AXES];
    logic signed [C_W-1:0] crs3_reg [NUM_TRIS][NUM_AXES];

    assign facec = facec_reg[LAT-1];

    always_comb
    begin
        tci = '0;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            case (face_pair_t'(facec[2:1]))
                PAIR_XY:
                begin
                    cxyz[k][0] = cres[k][0];
                    cxyz[k][1] = cres[k][1];
                    cxyz[k][2] = cres[k][2];
                end
                PAIR_YZ:
                begin
                    cxyz[k][2] = cres[k][0];
                    cxyz[k][0] = cres[k][1];
                    cxyz[k][1] = cres[k][2];
                end
                PAIR_ZX:
                begin
                    cxyz[k][1] = cres[k][0];
                    cxyz[k][2] = cres[k][1];
                    cxyz[k][0] = cres[k][2];
                end
                default:
                begin
                    cxyz[k][0] = cres[k][0];
                    cxyz[k][1] = cres[k][1];
                    cxyz[k][2] = cres[k][2];
                end
            endcase
        end
        for (int t = 0; t < NUM_TRIS; t++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                tci = facec[0] ? WIND_NEG[3 * t + j] : WIND_POS[3 * t + j];
                for (int q = 0; q < NUM_AXES; q++)
                begin
                    tv[t][j][q] = cxyz[tci][q];
                end
            end
            for (int q = 0; q < NUM_AXES; q++)
            begin
                ea[t][q] = DF_W'(tv[t][1][q]) - DF_W'(tv[t][0][q]);
                eb[t][q] = DF_W'(tv[t][2][q]) - DF_W'(tv[t][1][q]);
            end
            crs[t][0] = ea[t][1] * eb[t][2] - ea[t][2] * eb[t][1];
            crs[t][1] = ea[t][2] * eb[t][0] - ea[t][0] * eb[t][2];
            crs[t][2] = ea[t][0] * eb[t][1] - ea[t][1] * eb[t][0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= vc_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face3_reg <= facec;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                for (int q = 0; q < NUM_AXES; q++)
                begin
                    cor3_reg[k][q] <= cxyz[k][q];
                end
            end
            for (int t = 0; t < NUM_TRIS; t++)
            begin
                for (int q = 0; q < NUM_AXES; q++)
                begin
                    crs3_reg[t][q] <= crs[t][q][C_W-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 4: normal squares
    logic [C_W-1:0]        nful [NUM_TRIS][NUM_AXES];
    logic [CM_W-1:0]       nmag [NUM_TRIS][NUM_AXES];
    logic [NVSQ_W-1:0]     nsqc [NUM_TRIS][NUM_AXES];
    logic [NSQ_W-1:0]      nsum [NUM_TRIS];

    logic                  v4_reg;
    logic [FACE_W-1:0]     face4_reg;
    logic signed [PW-1:0]  cor4_reg   [NUM_CORNERS][NUM_AXES];
    logic                  nneg4_reg  [NUM_TRIS][NUM_AXES];
    logic [NVSQ_W-1:0]     nvsq4_reg  [NUM_TRIS][NUM_AXES];
    logic [NSQ_W-1:0]      nsq4_reg   [NUM_TRIS];

    always_comb
    begin
        for (int t = 0; t < NUM_TRIS; t++)
        begin
            for (int q = 0; q < NUM_AXES; q++)
            begin
                nful[t][q] = crs3_reg[t][q][C_W-1] ? C_W'(-crs3_reg[t][q])
                                                   : C_W'(crs3_reg[t][q]);
                nmag[t][q] = nful[t][q][CM_W-1:0];
                nsqc[t][q] = nmag[t][q] * nmag[t][q];
            end
            nsum[t] = NSQ_W'(nsqc[t][0]) + NSQ_W'(nsqc[t][1]) + NSQ_W'(nsqc[t][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face4_reg <= face3_reg;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                for (int q = 0; q < NUM_AXES; q++)
                begin
                    cor4_reg[k][q] <= cor3_reg[k][q];
                end
            end
            for (int t = 0; t < NUM_TRIS; t++)
            begin
                nsq4_reg[t] <= nsum[t];
                for (int q = 0; q < NUM_AXES; q++)
                begin
                    nneg4_reg[t][q] <= crs3_reg[t][q][C_W-1];
                    nvsq4_reg[t][q] <= nsqc[t][q];
                end
            end
        end
    end

    // ---------------------------------------------------------------- normal scaling
    logic signed [PW-1:0] nres [NUM_TRIS][NUM_AXES];

    for (genvar gt = 0; gt < NUM_TRIS; gt++) begin : g_tri
        for (genvar gq = 0; gq < NUM_AXES; gq++) begin : g_axis
            csct_scale #(
                .FRAC  (FRAC_BITS),
                .SQ_W  (NSQ_W),
                .VSQ_W (NVSQ_W)
            ) u_scale (
                .clk (clk),
                .en  (en),
                .neg (nneg4_reg[gt][gq]),
                .vsq (nvsq4_reg[gt][gq]),
                .sq  (nsq4_reg[gt]),
                .res (nres[gt][gq])
            );
        end
    end

    logic [FACE_W-1:0]    facen_reg [LAT];
    logic signed [PW-1:0] corn_reg  [LAT][NUM_CORNERS][NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vn_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vn_reg[0] <= v4_reg;
            for (int i = 1; i < LAT; i++)
            begin
                vn_reg[i] <= vn_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            facen_reg[0] <= face4_reg;
            corn_reg[0]  <= cor4_reg;
            for (int i = 1; i < LAT; i++)
            begin
                facen_reg[i] <= facen_reg[i-1];
                corn_reg[i]  <= corn_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------- output word select
    corner_idx_t out_corner;
    logic        out_tri;

    assign out_corner = facen_reg[LAT-1][0] ? WIND_NEG[slot_reg] : WIND_POS[slot_reg];
    assign out_tri    = (slot_reg >= TRI1_SLOT);

    assign pos_x       = corn_reg[LAT-1][out_corner][0];
    assign pos_y       = corn_reg[LAT-1][out_corner][1];
    assign pos_z       = corn_reg[LAT-1][out_corner][2];
    assign norm_x      = nres[out_tri][0];
    assign norm_y      = nres[out_tri][1];
    assign norm_z      = nres[out_tri][2];
    assign vertex_slot = slot_reg;
    assign last_vertex = (slot_reg == LAST_SLOT);

`ifndef SYNTHESIS
    // input is held back only while a finished cell sits at the output
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output stage");

    // slot counter stays inside the six vertices
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("vertex slot out of range");

    // a new cell always starts at vertex zero
    a_slot_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> (slot_reg == '0))
        else $error("slot counter not at zero while output empty");

    // after the sixth word the counter wraps
    a_slot_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && (slot_reg == LAST_SLOT)) |=> (slot_reg == '0))
        else $error("slot counter did not wrap after last vertex");
`endif

endmodule
